/* rtl/motor_latch_run_detector_assert.svh */
// assertion macros shared by the rtl files
`ifndef MOTOR_LATCH_RUN_DETECTOR_ASSERT_SVH
`define MOTOR_LATCH_RUN_DETECTOR_ASSERT_SVH

// clocked check, off while reset is high
`define MLRD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also during reset
`define MLRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mlrd_pkg.sv */
// ----------------------------------------------------------------------------
// mlrd_pkg
// Types and constants shared by the motor latch run detector.
// ----------------------------------------------------------------------------
package mlrd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int LIMIT_BITS  = 17;

  localparam logic [15:0] SETTLE_MS     = 16'd50;
  localparam logic [15:0] MIN_LATCH_MS  = 16'd100;
  localparam logic [7:0]  MIN_LOW_COUNT = 8'd4;
  localparam logic [7:0]  LOW_COUNT_MAX = 8'd255;

  localparam logic [9:0]  THRESHOLD_RESET = 10'd8;
  localparam logic [14:0] SWEEP_RESET     = 15'd9000;
  localparam logic [12:0] BACKLASH_RESET  = 13'd1800;

  localparam int CFG_DATA_BITS = 15;

  typedef enum logic [1:0] {
    REG_LATCH_THRESHOLD = 2'd0,
    REG_SWEEP_MS        = 2'd1,
    REG_BACKLASH_OPEN   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  latch_threshold;
    logic [14:0] sweep_ms;
    logic [12:0] backlash_open_ms;
  } cfg_t;

  typedef struct packed {
    logic                   start_run;
    logic                   open_dir;
    logic [SAMPLE_BITS-1:0] sample;
    logic [15:0]            elapsed_ms;
  } in_beat_t;

  typedef struct packed {
    logic                   motor_on;
    logic                   drive_open;
    logic                   latched;
    logic                   timed_out;
    logic [SAMPLE_BITS-1:0] current_estimate;
    logic [14:0]            position_ms;
    logic [15:0]            run_time_ms;
  } out_beat_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] estimate;
    logic [7:0]             low_count;
  } filt_t;

endpackage

/* rtl/mlrd_filter.sv */
// ----------------------------------------------------------------------------
// mlrd_filter
// Current estimate filter and low-sample run counter for one sample.
// ----------------------------------------------------------------------------
module mlrd_filter (
  input  logic [mlrd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                             settled,
  input  logic [9:0]                       latch_threshold,
  input  mlrd_pkg::filt_t                  cur,
  output mlrd_pkg::filt_t                  nxt
);

  logic [mlrd_pkg::SUM_BITS-1:0]    sum;
  logic [mlrd_pkg::SAMPLE_BITS-1:0] avg;
  logic [mlrd_pkg::SAMPLE_BITS-1:0] iir;
  logic                             is_low;

  // sample + 3 * estimate, then quarter
  assign sum = {2'b00, sample} + {1'b0, cur.estimate, 1'b0} + {2'b00, cur.estimate};
  assign avg = sum[mlrd_pkg::SUM_BITS-1:2];

  // nudge one count toward the sample when the filter stalls
  always_comb begin
    iir = avg;
    if (avg == cur.estimate) begin
      if (sample > avg) begin
        iir = avg + mlrd_pkg::SAMPLE_BITS'(1);
      end else if (sample < avg) begin
        iir = avg - mlrd_pkg::SAMPLE_BITS'(1);
      end
    end
  end

  assign is_low = ({{(16 - mlrd_pkg::SAMPLE_BITS){1'b0}}, sample} <= {6'd0, latch_threshold});

  always_comb begin
    if (!settled) begin
      nxt.estimate  = sample;
      nxt.low_count = cur.low_count;
    end else begin
      nxt.estimate = iir;
      if (!is_low) begin
        nxt.low_count = 8'd0;
      end else if (cur.low_count != mlrd_pkg::LOW_COUNT_MAX) begin
        nxt.low_count = cur.low_count + 8'd1;
      end else begin
        nxt.low_count = cur.low_count;
      end
    end
  end

endmodule

/* rtl/mlrd_core.sv */
// ----------------------------------------------------------------------------
// mlrd_core
// Run state registers and the per-beat decision: start, filter, timeout, latch.
// ----------------------------------------------------------------------------
`include "motor_latch_run_detector_assert.svh"

module mlrd_core (
  input  logic                clk,
  input  logic                rst,
  input  mlrd_pkg::cfg_t      cfg,
  input  logic                step_en,
  input  mlrd_pkg::in_beat_t  item,
  output mlrd_pkg::out_beat_t res
);

  logic                             running;
  logic                             direction_open;
  logic [mlrd_pkg::SAMPLE_BITS-1:0] estimate;
  logic [7:0]                       low_count;
  logic [15:0]                      prior_elapsed;
  logic [14:0]                      position;

  logic                             running_next;
  logic                             direction_open_next;
  logic [mlrd_pkg::SAMPLE_BITS-1:0] estimate_next;
  logic [7:0]                       low_count_next;
  logic [15:0]                      prior_elapsed_next;
  logic [14:0]                      position_next;

  mlrd_pkg::filt_t                  filt_cur;
  mlrd_pkg::filt_t                  filt_nxt;
  logic [mlrd_pkg::LIMIT_BITS-1:0]  limit;
  logic                             over_limit;
  logic                             latch_hit;
  logic                             did_latch;
  logic                             did_timeout;

  assign filt_cur.estimate  = estimate;
  assign filt_cur.low_count = low_count;

  mlrd_filter u_filter (
    .sample          (item.sample),
    .settled         (prior_elapsed >= mlrd_pkg::SETTLE_MS),
    .latch_threshold (cfg.latch_threshold),
    .cur             (filt_cur),
    .nxt             (filt_nxt)
  );

  // 3 * backlash + 2 * sweep
  assign limit = {4'b0, cfg.backlash_open_ms} + {3'b0, cfg.backlash_open_ms, 1'b0}
               + {1'b0, cfg.sweep_ms, 1'b0};
  assign over_limit = ({1'b0, item.elapsed_ms} > limit);
  assign latch_hit  = (item.elapsed_ms >= mlrd_pkg::MIN_LATCH_MS)
                   && (filt_nxt.low_count >= mlrd_pkg::MIN_LOW_COUNT);

  always_comb begin
    running_next        = running;
    direction_open_next = direction_open;
    estimate_next       = estimate;
    low_count_next      = low_count;
    prior_elapsed_next  = prior_elapsed;
    position_next       = position;
    did_latch           = 1'b0;
    did_timeout         = 1'b0;
    if (item.start_run) begin
      running_next        = 1'b1;
      direction_open_next = item.open_dir;
      estimate_next       = '0;
      low_count_next      = '0;
      prior_elapsed_next  = '0;
    end else if (running) begin
      estimate_next      = filt_nxt.estimate;
      low_count_next     = filt_nxt.low_count;
      prior_elapsed_next = item.elapsed_ms;
      if (over_limit) begin
        did_timeout  = 1'b1;
        running_next = 1'b0;
      end else if (latch_hit) begin
        did_latch     = 1'b1;
        running_next  = 1'b0;
        position_next = direction_open ? cfg.sweep_ms : 15'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      direction_open <= 1'b0;
      estimate       <= '0;
      low_count      <= '0;
      prior_elapsed  <= '0;
      position       <= '0;
    end else if (step_en) begin
      running        <= running_next;
      direction_open <= direction_open_next;
      estimate       <= estimate_next;
      low_count      <= low_count_next;
      prior_elapsed  <= prior_elapsed_next;
      position       <= position_next;
    end
  end

  assign res.motor_on         = running_next;
  assign res.drive_open       = running_next && direction_open_next;
  assign res.latched          = did_latch;
  assign res.timed_out        = did_timeout;
  assign res.current_estimate = estimate_next;
  assign res.position_ms      = position_next;
  assign res.run_time_ms      = (did_latch || did_timeout) ? item.elapsed_ms : 16'd0;

  `MLRD_ASSERT_CLK(a_end_stops_run, step_en && (res.latched || res.timed_out) |=> !running, "run still active after it ended")
  `MLRD_ASSERT_CLK(a_start_clears, step_en && item.start_run |=> running && estimate == '0 && low_count == '0, "start beat did not clear run state")
  `MLRD_ASSERT_CLK(a_idle_holds, step_en && !item.start_run && !running |=> $stable(estimate) && $stable(position), "sample while idle changed state")
  `MLRD_ASSERT_CLK(a_open_latch_pos, step_en && res.latched && direction_open |=> position == $past(cfg.sweep_ms), "open latch did not set position to sweep")

endmodule

/* rtl/motor_latch_run_detector.sv */
// ----------------------------------------------------------------------------
// motor_latch_run_detector
// Damper motor run tracker: filters current samples and ends a run on latch
// or timeout, one beat in and one beat out per cycle unless out stalls.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid / in_ready / in_data    beat in: start or sample
//  out       out_valid / out_ready / out_data beat out: one result per beat
//  cfg       cfg_wr_en / cfg_index / cfg_wdata  register write, no wait
//
// one beat per cycle sustained unless out stalls; an accepted beat passes the
// input register, then the result register after the single-pass core logic
// sync reset clears run state and loads register defaults
// a stall on out holds the result register; in_ready drops only when both
// registers are full and out_ready is low
`include "motor_latch_run_detector_assert.svh"

module motor_latch_run_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mlrd_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mlrd_pkg::out_beat_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [mlrd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  mlrd_pkg::cfg_t      cfg;
  mlrd_pkg::in_beat_t  item;
  logic                item_valid;
  logic                advance;
  logic                step_en;
  mlrd_pkg::out_beat_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.latch_threshold  <= mlrd_pkg::THRESHOLD_RESET;
      cfg.sweep_ms         <= mlrd_pkg::SWEEP_RESET;
      cfg.backlash_open_ms <= mlrd_pkg::BACKLASH_RESET;
    end else if (cfg_wr_en) begin
      unique case (mlrd_pkg::cfg_reg_t'(cfg_index))
        mlrd_pkg::REG_LATCH_THRESHOLD: cfg.latch_threshold  <= cfg_wdata[9:0];
        mlrd_pkg::REG_SWEEP_MS:        cfg.sweep_ms         <= cfg_wdata[14:0];
        mlrd_pkg::REG_BACKLASH_OPEN:   cfg.backlash_open_ms <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // result register frees up when empty or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;
  assign step_en  = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  mlrd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (step_en),
    .item    (item),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= res;
    end
  end

  `MLRD_ASSERT_CLK(a_full_when_blocked, !in_ready |-> item_valid && out_valid && !out_ready, "in_ready low without a full pipeline")
  `MLRD_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid && !item_valid, "pipeline not empty after reset")

endmodule

/* tb/tb_motor_latch_run_detector.sv */
// ----------------------------------------------------------------------------
// tb_motor_latch_run_detector
// Self-checking bench for the damper motor run tracker. A directed table
// covers reset values, start/idle handling, latch vs timeout and backward
// elapsed time; random runs with random idling and a long output stall follow
// under several register settings. Every result beat is compared field by
// field against the table's expected beat or an in-bench run state model.
// ----------------------------------------------------------------------------
module tb_motor_latch_run_detector;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int BEATS_PER_PASS = 240;
  localparam int HOLD_CYCLES    = 300;
  localparam int SAT_SAMPLES    = 257;

  typedef struct packed {
    mlrd_pkg::in_beat_t  stim;
    logic                known;
    mlrd_pkg::out_beat_t want;
  } directed_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  mlrd_pkg::in_beat_t                 in_data = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  mlrd_pkg::out_beat_t                out_data;
  logic                               cfg_wr_en = 1'b0;
  logic [1:0]                         cfg_index = mlrd_pkg::REG_LATCH_THRESHOLD;
  logic [mlrd_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // run state model
  logic                             run_on = 1'b0;
  logic                             run_open = 1'b0;
  logic [mlrd_pkg::SAMPLE_BITS-1:0] est_cnt = '0;
  logic [7:0]                       low_run = '0;
  logic [15:0]                      prev_ms = '0;
  logic [14:0]                      pos_ms = '0;
  logic [9:0]                       thr_cfg = mlrd_pkg::THRESHOLD_RESET;
  logic [14:0]                      sweep_cfg = mlrd_pkg::SWEEP_RESET;
  logic [12:0]                      backlash_cfg = mlrd_pkg::BACKLASH_RESET;

  mlrd_pkg::out_beat_t pending_status [$];
  mlrd_pkg::out_beat_t head_status;
  int                  errors = 0;
  int                  beats_sent = 0;
  int                  cycle_count = 0;
  int                  tx_idle_pct = 13;
  int                  rx_idle_pct = 52;
  logic                hold_arm = 1'b0;
  logic                stall_rx;

  directed_row_t directed_rows [24] = '{
    // sample while idle after reset
    {1'b0, 1'b1, 10'd1023, 16'd65535, 1'b1, 4'b0000, 10'd0,    15'd0,    16'd0},
    // start open, sample and elapsed ignored
    {1'b1, 1'b1, 10'd1023, 16'd65535, 1'b1, 4'b1100, 10'd0,    15'd0,    16'd0},
    {1'b0, 1'b0, 10'd1023, 16'd0,     1'b1, 4'b1100, 10'd1023, 15'd0,    16'd0},
    {1'b0, 1'b1, 10'd0,    16'd50,    1'b1, 4'b1100, 10'd0,    15'd0,    16'd0},
    {1'b0, 1'b0, 10'd0,    16'd60,    1'b1, 4'b1100, 10'd0,    15'd0,    16'd0},
    {1'b0, 1'b0, 10'd8,    16'd70,    1'b0, 45'd0},
    // filter stalls, nudge one count up
    {1'b0, 1'b0, 10'd3,    16'd80,    1'b0, 45'd0},
    {1'b0, 1'b0, 10'd0,    16'd99,    1'b0, 45'd0},
    // latch while opening
    {1'b0, 1'b0, 10'd0,    16'd100,   1'b0, 45'd0},
    {1'b0, 1'b1, 10'd1023, 16'd65535, 1'b0, 45'd0},
    // start keeps position, second start replaces the run
    {1'b1, 1'b0, 10'd0,    16'd0,     1'b1, 4'b1000, 10'd0,    15'd9000, 16'd0},
    {1'b1, 1'b1, 10'd0,    16'd0,     1'b1, 4'b1100, 10'd0,    15'd9000, 16'd0},
    {1'b0, 1'b0, 10'd0,    16'd60,    1'b0, 45'd0},
    {1'b0, 1'b0, 10'd0,    16'd70,    1'b0, 45'd0},
    {1'b0, 1'b0, 10'd0,    16'd80,    1'b0, 45'd0},
    {1'b0, 1'b0, 10'd0,    16'd90,    1'b0, 45'd0},
    // latch and timeout on the same beat, timeout wins
    {1'b0, 1'b0, 10'd0,    16'd23401, 1'b0, 45'd0},
    {1'b1, 1'b0, 10'd0,    16'd0,     1'b1, 4'b1000, 10'd0,    15'd9000, 16'd0},
    {1'b0, 1'b0, 10'd0,    16'd60,    1'b0, 45'd0},
    {1'b0, 1'b0, 10'd0,    16'd70,    1'b0, 45'd0},
    {1'b0, 1'b0, 10'd0,    16'd80,    1'b0, 45'd0},
    {1'b0, 1'b1, 10'd0,    16'd90,    1'b0, 45'd0},
    // elapsed steps backward below the latch floor
    {1'b0, 1'b0, 10'd0,    16'd30,    1'b0, 45'd0},
    // latch right at the timeout limit while closing
    {1'b0, 1'b0, 10'd0,    16'd23400, 1'b0, 45'd0}
  };

  motor_latch_run_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_motor_latch_run_detector: done, errors");
      $finish;
    end
  end

  function automatic mlrd_pkg::out_beat_t advance_run(input mlrd_pkg::in_beat_t b);
    mlrd_pkg::out_beat_t r;
    int                  nxt;
    int                  limit_ms;
    r = '0;
    if (b.start_run) begin
      run_on   = 1'b1;
      run_open = b.open_dir;
      est_cnt  = '0;
      low_run  = '0;
      prev_ms  = '0;
    end else if (run_on) begin
      if (prev_ms < mlrd_pkg::SETTLE_MS) begin
        est_cnt = b.sample;
      end else begin
        nxt = (int'(b.sample) + 3 * int'(est_cnt)) >> 2;
        if (nxt == int'(est_cnt)) begin
          if (int'(b.sample) > nxt) nxt++;
          else if (int'(b.sample) < nxt) nxt--;
        end
        est_cnt = mlrd_pkg::SAMPLE_BITS'(nxt);
        if (b.sample > thr_cfg) low_run = '0;
        else if (low_run != mlrd_pkg::LOW_COUNT_MAX) low_run = low_run + 8'd1;
      end
      prev_ms  = b.elapsed_ms;
      limit_ms = 3 * int'(backlash_cfg) + 2 * int'(sweep_cfg);
      if (int'(b.elapsed_ms) > limit_ms) begin
        r.timed_out   = 1'b1;
        r.run_time_ms = b.elapsed_ms;
        run_on        = 1'b0;
      end else if (b.elapsed_ms >= mlrd_pkg::MIN_LATCH_MS
                   && low_run >= mlrd_pkg::MIN_LOW_COUNT) begin
        r.latched     = 1'b1;
        r.run_time_ms = b.elapsed_ms;
        run_on        = 1'b0;
        pos_ms        = run_open ? sweep_cfg : 15'd0;
      end
    end
    r.motor_on         = run_on;
    r.drive_open       = run_on & run_open;
    r.current_estimate = est_cnt;
    r.position_ms      = pos_ms;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none got %h",
                   $time, out_data);
          errors++;
        end else begin
          head_status = pending_status.pop_front();
          check_field("motor_on", 16'(head_status.motor_on), 16'(out_data.motor_on));
          check_field("drive_open", 16'(head_status.drive_open),
                      16'(out_data.drive_open));
          check_field("latched", 16'(head_status.latched), 16'(out_data.latched));
          check_field("timed_out", 16'(head_status.timed_out), 16'(out_data.timed_out));
          check_field("current_estimate", 16'(head_status.current_estimate),
                      16'(out_data.current_estimate));
          check_field("position_ms", 16'(head_status.position_ms),
                      16'(out_data.position_ms));
          check_field("run_time_ms", head_status.run_time_ms, out_data.run_time_ms);
        end
      end
      out_ready <= !stall_rx && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long output stall so the pipeline fills and in_ready drops
  initial begin
    stall_rx = 1'b0;
    wait (hold_arm);
    @(posedge clk);
    stall_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_rx <= 1'b0;
  end

  task automatic send_beat(input mlrd_pkg::in_beat_t b, input logic known,
                           input mlrd_pkg::out_beat_t want);
    int                  gap;
    mlrd_pkg::out_beat_t got;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = advance_run(b);
    pending_status.push_back(known ? want : got);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [9:0] thr, input logic [14:0] sw,
                            input logic [12:0] bl);
    drain();
    // let the two pipeline stages settle
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= mlrd_pkg::REG_LATCH_THRESHOLD;
    cfg_wdata <= mlrd_pkg::CFG_DATA_BITS'(thr);
    @(posedge clk);
    cfg_index <= mlrd_pkg::REG_SWEEP_MS;
    cfg_wdata <= sw;
    @(posedge clk);
    cfg_index <= mlrd_pkg::REG_BACKLASH_OPEN;
    cfg_wdata <= mlrd_pkg::CFG_DATA_BITS'(bl);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    thr_cfg      = thr;
    sweep_cfg    = sw;
    backlash_cfg = bl;
  endtask

  // start, then samples that begin high and fall toward the threshold
  task automatic drive_run();
    mlrd_pkg::in_beat_t b;
    int                 n_samples;
    int                 n_high;
    int                 t_ms;
    int                 step;
    n_samples    = $urandom_range(1, 40);
    n_high       = $urandom_range(0, n_samples);
    b.start_run  = 1'b1;
    b.open_dir   = 1'($urandom);
    b.sample     = mlrd_pkg::SAMPLE_BITS'($urandom);
    b.elapsed_ms = 16'($urandom);
    send_beat(b, 1'b0, '0);
    t_ms = $urandom_range(0, 30);
    for (int i = 0; i < n_samples; i++) begin
      b.start_run = 1'b0;
      b.open_dir  = 1'($urandom);
      if ($urandom_range(9) == 0) begin
        b.sample = mlrd_pkg::SAMPLE_BITS'($urandom);
      end else if (i < n_high) begin
        b.sample = mlrd_pkg::SAMPLE_BITS'($urandom_range(int'(thr_cfg), 1023));
      end else begin
        b.sample = mlrd_pkg::SAMPLE_BITS'($urandom_range(0, int'(thr_cfg)));
      end
      b.elapsed_ms = 16'(t_ms);
      send_beat(b, 1'b0, '0);
      if ($urandom_range(29) == 0) step = $urandom_range(20000, 65535);
      else if ($urandom_range(4) == 0) step = $urandom_range(0, 9000);
      else if ($urandom_range(19) == 0) step = -int'($urandom_range(0, 200));
      else step = $urandom_range(1, 40);
      t_ms = t_ms + step;
      if (t_ms < 0) t_ms = 0;
      if (t_ms > 65535) t_ms = 65535;
    end
  endtask

  // over 255 low samples below the latch floor saturate the count, then latch
  task automatic drive_saturation();
    mlrd_pkg::in_beat_t b;
    b.start_run  = 1'b1;
    b.open_dir   = 1'($urandom);
    b.sample     = '0;
    b.elapsed_ms = '0;
    send_beat(b, 1'b0, '0);
    b.start_run  = 1'b0;
    b.elapsed_ms = mlrd_pkg::SETTLE_MS;
    send_beat(b, 1'b0, '0);
    for (int i = 0; i <= SAT_SAMPLES; i++) begin
      b.sample     = mlrd_pkg::SAMPLE_BITS'($urandom_range(0, int'(thr_cfg)));
      b.elapsed_ms = (i == SAT_SAMPLES) ? mlrd_pkg::MIN_LATCH_MS
                                        : 16'($urandom_range(50, 99));
      send_beat(b, 1'b0, '0);
    end
  endtask

  initial begin
    mlrd_pkg::in_beat_t b;
    int                 pass_idx;
    int                 pass_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);

    for (int mode = 0; mode < 3; mode++) begin
      for (int k = 0; k < 2; k++) begin
        pass_idx    = 2 * mode + k;
        tx_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 52 : 0;
        rx_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 13 : 0;
        case (pass_idx)
          0: write_regs(10'd0, 15'd0, 13'd0);
          1: write_regs(10'd1023, 15'd20000, 13'd8000);
          default: write_regs($urandom_range(1) ? 10'($urandom_range(0, 63))
                                                : 10'($urandom_range(0, 1023)),
                              15'($urandom_range(0, 20000)),
                              13'($urandom_range(0, 8000)));
        endcase
        pass_start = beats_sent;
        if (pass_idx == 1) begin
          drive_saturation();
          drive_saturation();
        end
        while (beats_sent - pass_start < BEATS_PER_PASS) begin
          if (pass_idx == 4 && !hold_arm && beats_sent - pass_start >= 40)
            hold_arm <= 1'b1;
          if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 5)) begin
              b            = '0;
              b.start_run  = ($urandom_range(3) == 0);
              b.open_dir   = 1'($urandom);
              b.sample     = mlrd_pkg::SAMPLE_BITS'($urandom);
              b.elapsed_ms = 16'($urandom);
              send_beat(b, 1'b0, '0);
            end
          end else begin
            drive_run();
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_motor_latch_run_detector: done, clean");
    end else begin
      $display("tb_motor_latch_run_detector: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mlrd_pkg.sv
rtl/mlrd_filter.sv
rtl/mlrd_core.sv
rtl/motor_latch_run_detector.sv
tb/tb_motor_latch_run_detector.sv
